// ===== rtl/vdn_pkg.sv =====
package vdn_pkg;

  localparam int ACC_BITS  = 48;
  localparam int INV_BITS  = 40;
  localparam int ROOT_BITS = INV_BITS + 1;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 3;
  localparam int HALF_INV  = INV_BITS / 2;

  localparam logic [1:0] MODE_L2    = 2'd0;
  localparam logic [1:0] MODE_DOT   = 2'd1;
  localparam logic [1:0] MODE_NORM  = 2'd2;
  localparam logic [1:0] MODE_SCALE = 2'd3;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic root_store;
    logic zero_store;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       vec_end;
    logic       sum_pos;
  } sts_t;

endpackage

// ===== rtl/vector_distance_normalize.sv =====
// Channel  | Handshake             | Payload
// in_      | in_valid / in_stall   | mode, elem_a, elem_b, last
// out_     | out_valid / out_stall | value, zero_norm, end_of_vector
//
// Each element goes through load, multiply and accumulate steps, and a result, when one is due,
// is written into the output register. The end of a norm pass with a positive sum adds a
// shift-subtract division and a bit-serial square root before that write.
// Synchronous active-low reset clears the accumulator, count, inverse root and flag.
// A new element is taken while an earlier result waits on out_stall.
module vector_distance_normalize import vdn_pkg::*; #(
  parameter int MAX_DIM   = 1024,
  parameter int ELEM_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_mode,
  input  logic signed [15:0]         in_elem_a,
  input  logic signed [15:0]         in_elem_b,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [ACC_BITS-1:0] out_value,
  output logic                       out_zero_norm,
  output logic                       out_end_of_vector
);

  cmd_t cmd;
  sts_t sts;

  vdn_ctrl #(
    .ELEM_BITS(ELEM_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vdn_dp #(
    .MAX_DIM  (MAX_DIM),
    .ELEM_BITS(ELEM_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_elem_a        (in_elem_a),
    .in_elem_b        (in_elem_b),
    .in_last          (in_last),
    .out_value        (out_value),
    .out_zero_norm    (out_zero_norm),
    .out_end_of_vector(out_end_of_vector)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after transfer");

  a_zero_norm_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |-> out_value[ACC_BITS-1] || out_value == '0)
    else $error("zero_norm result with positive value");

  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_vector |->
      (&out_value[ACC_BITS-1:ELEM_BITS-1]) || !(|out_value[ACC_BITS-1:ELEM_BITS-1]))
    else $error("scaled element outside element range");
`endif

endmodule

// ===== rtl/vdn_ctrl.sv =====
module vdn_ctrl import vdn_pkg::*; #(
  parameter int ELEM_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int QW  = 2 * (ELEM_BITS + 22) + 1;
  localparam int SCW = $clog2(QW);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_DIV, S_SQI, S_SQRT, S_ROOT, S_EMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [SCW-1:0] step_r, step_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.mode == MODE_SCALE) begin
          state_nxt = S_EMIT;
        end else if (!sts.vec_end) begin
          state_nxt = S_IDLE;
        end else if (sts.mode == MODE_NORM && sts.sum_pos) begin
          cmd.div_init = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_DIV;
        end else if (sts.mode == MODE_NORM) begin
          cmd.zero_store = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == SCW'(QW - 1)) begin
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == SCW'(ROOT_BITS - 1)) begin
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root_store = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/vdn_dp.sv =====
module vdn_dp import vdn_pkg::*; #(
  parameter int MAX_DIM   = 1024,
  parameter int ELEM_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic [1:0]                 in_mode,
  input  logic signed [15:0]         in_elem_a,
  input  logic signed [15:0]         in_elem_b,
  input  logic                       in_last,
  output logic signed [ACC_BITS-1:0] out_value,
  output logic                       out_zero_norm,
  output logic                       out_end_of_vector
);

  localparam int E   = ELEM_BITS;
  localparam int XW  = (E > 16) ? E : 16;
  localparam int OW  = E + 1;
  localparam int PW  = 2 * OW;
  localparam int SW  = ((PW > ACC_BITS) ? PW : ACC_BITS) + 1;
  localparam int QW  = 2 * (E + 22) + 1;
  localparam int QRW = (QW > RAD_BITS) ? QW : RAD_BITS;
  localparam int LW  = E + HALF_INV + 1;
  localparam int PSW = E + INV_BITS + 2;
  localparam int CW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic signed [SW-1:0]  TMAX = SW'({1'b0, {(ACC_BITS - 1){1'b1}}});
  localparam logic signed [SW-1:0]  TMIN = -TMAX - 1;
  localparam logic signed [PSW-1:0] RND  = PSW'(1 <<< 23);
  localparam logic signed [PSW-1:0] SMAX = PSW'((1 <<< (E - 1)) - 1);
  localparam logic signed [PSW-1:0] SMIN = PSW'(-(1 <<< (E - 1)));

  logic signed [E-1:0]        a_r, b_r;
  logic [1:0]                 mode_r;
  logic                       end_r;
  logic [CW-1:0]              cnt_r;
  logic signed [PW-1:0]       prod_r;
  logic signed [LW-1:0]       plo_r;
  logic signed [ACC_BITS-1:0] acc_r, res_r;
  logic                       zf_r;
  logic [INV_BITS-1:0]        inv_r;
  logic                       nz_r;
  logic [ACC_BITS-1:0]        s_r, r_r;
  logic [QRW-1:0]             q_r;
  logic                       first_r;
  logic [RAD_BITS-1:0]        rad_r;
  logic [REM_BITS-1:0]        rem_r;
  logic [ROOT_BITS-1:0]       root_r;
  logic signed [ACC_BITS-1:0] val_r;
  logic                       zn_r, eov_r;

  logic [XW-1:0]              a_x, b_x;
  logic                       end_c;
  logic signed [OW-1:0]       x_op, y_op, d_op;
  logic signed [PW-1:0]       prod_c;
  logic signed [LW-1:0]       plo_c, phi_c;
  logic signed [SW-1:0]       t_ext, t_sat, sum_c;
  logic signed [ACC_BITS-1:0] sum_sat;
  logic signed [PSW-1:0]      p_c, rnd_c;
  logic signed [E-1:0]        scale_c;
  logic [ACC_BITS-1:0]        rs_c;
  logic                       qb_c;
  logic [REM_BITS-1:0]        rem2_c, trial_c;

  assign a_x   = XW'($unsigned(in_elem_a));
  assign b_x   = XW'($unsigned(in_elem_b));
  assign end_c = in_last || (cnt_r == CW'(MAX_DIM - 1));

  always_comb begin
    d_op = OW'(a_r) - OW'(b_r);
    case (mode_r)
      MODE_L2:  begin x_op = d_op;      y_op = d_op;      end
      MODE_DOT: begin x_op = OW'(a_r);  y_op = OW'(b_r);  end
      default:  begin x_op = OW'(a_r);  y_op = OW'(a_r);  end
    endcase
  end

  assign prod_c = x_op * y_op;
  assign plo_c  = a_r * signed'({1'b0, inv_r[HALF_INV-1:0]});
  assign phi_c  = a_r * signed'({1'b0, inv_r[INV_BITS-1:HALF_INV]});

  always_comb begin
    t_ext = SW'(prod_r);
    if (t_ext > TMAX) begin
      t_sat = TMAX;
    end else if (t_ext < TMIN) begin
      t_sat = TMIN;
    end else begin
      t_sat = t_ext;
    end
    sum_c = SW'(acc_r) + t_sat;
    if (sum_c > TMAX) begin
      sum_sat = ACC_BITS'(TMAX);
    end else if (sum_c < TMIN) begin
      sum_sat = ACC_BITS'(TMIN);
    end else begin
      sum_sat = ACC_BITS'(sum_c);
    end
  end

  always_comb begin
    p_c   = (PSW'(phi_c) <<< HALF_INV) + PSW'(plo_r);
    rnd_c = (p_c + RND) >>> 24;
    if (nz_r) begin
      scale_c = '0;
    end else if (rnd_c > SMAX) begin
      scale_c = E'(SMAX);
    end else if (rnd_c < SMIN) begin
      scale_c = E'(SMIN);
    end else begin
      scale_c = E'(rnd_c);
    end
  end

  assign rs_c    = {r_r[ACC_BITS-2:0], first_r};
  assign qb_c    = (rs_c >= s_r);
  assign rem2_c  = {rem_r[REM_BITS-3:0], rad_r[RAD_BITS-1:RAD_BITS-2]};
  assign trial_c = {1'b0, root_r, 2'b01};

  assign sts.mode    = mode_r;
  assign sts.vec_end = end_r;
  assign sts.sum_pos = !sum_sat[ACC_BITS-1] && (|sum_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      acc_r <= '0;
      inv_r <= '0;
      nz_r  <= 1'b1;
    end else begin
      if (cmd.load) begin
        cnt_r <= end_c ? '0 : cnt_r + 1'b1;
      end
      if (cmd.acc) begin
        if (end_r) begin
          acc_r <= '0;
        end else if (mode_r != MODE_SCALE) begin
          acc_r <= sum_sat;
        end
      end
      if (cmd.zero_store) begin
        inv_r <= '0;
        nz_r  <= 1'b1;
      end
      if (cmd.root_store) begin
        inv_r <= root_r[ROOT_BITS-1] ? '1 : root_r[INV_BITS-1:0];
        nz_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= signed'(a_x[E-1:0]);
      b_r    <= signed'(b_x[E-1:0]);
      mode_r <= in_mode;
      end_r  <= end_c;
    end
    if (cmd.mul) begin
      prod_r <= prod_c;
      plo_r  <= plo_c;
    end
    if (cmd.acc) begin
      if (mode_r == MODE_SCALE) begin
        res_r <= ACC_BITS'(scale_c);
        zf_r  <= nz_r;
      end else begin
        res_r <= sum_sat;
        zf_r  <= cmd.zero_store;
      end
    end
    if (cmd.root_store) begin
      zf_r <= 1'b0;
    end
    if (cmd.div_init) begin
      s_r     <= sum_sat;
      r_r     <= '0;
      q_r     <= '0;
      first_r <= 1'b1;
    end
    if (cmd.div_step) begin
      r_r     <= qb_c ? rs_c - s_r : rs_c;
      q_r     <= {q_r[QRW-2:0], qb_c};
      first_r <= 1'b0;
    end
    if (cmd.sqrt_init) begin
      rad_r  <= (|(q_r >> (RAD_BITS - 2))) ? (RAD_BITS'(1) << (RAD_BITS - 2))
                                           : q_r[RAD_BITS-1:0];
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      rad_r <= rad_r << 2;
      if (rem2_c >= trial_c) begin
        rem_r  <= rem2_c - trial_c;
        root_r <= {root_r[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem2_c;
        root_r <= {root_r[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      val_r <= res_r;
      zn_r  <= zf_r;
      eov_r <= end_r;
    end
  end

  assign out_value         = val_r;
  assign out_zero_norm     = zn_r;
  assign out_end_of_vector = eov_r;

endmodule

// ===== sim/vector_distance_normalize_tb.sv =====
module vector_distance_normalize_tb;
  import vdn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VEC_MAX   = 1024;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 140;

  typedef struct {
    logic [1:0]         mode;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
    bit                 hold;
  } elem_t;

  typedef struct {
    logic signed [47:0] value;
    logic               zero_norm;
    logic               eov;
  } sum_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_last;
  logic [1:0] in_mode;
  logic signed [15:0] in_elem_a, in_elem_b;
  logic out_valid, out_stall, out_zero_norm, out_end_of_vector;
  logic signed [47:0] out_value;

  vector_distance_normalize DUT (.*);

  elem_t pending[$];
  sum_t  sums_due[$];
  elem_t cur;

  longint     acc;
  logic [39:0] inv_pred;
  bit         norm_zero;
  int         elem_cnt;

  int  mismatches, idle_cycles, in_gap, out_gap, hold_cnt;
  bit  quiet, holding, failed;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [39:0] inv_root_of(logic [47:0] s);
    logic [40:0]  x, t;
    logic [191:0] prod;
    x = '0;
    for (int i = 40; i >= 0; i--) begin
      t = x | (41'd1 << i);
      prod = {151'd0, t} * {151'd0, t} * {144'd0, s};
      if (prod <= (192'd1 << 76)) x = t;
    end
    return x[40] ? 40'hFF_FFFF_FFFF : x[39:0];
  endfunction

  function automatic longint sat48(longint v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  task automatic predict_elem(elem_t e);
    longint a, b, term, p, r;
    bit vend;
    sum_t s;
    a = e.a;
    b = e.b;
    vend = e.last || (elem_cnt + 1 >= VEC_MAX);
    s.eov = vend;
    s.zero_norm = 1'b0;
    if (e.mode == MODE_SCALE) begin
      p = a * longint'({24'd0, inv_pred});
      r = (p + (64'sd1 <<< 23)) >>> 24;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      s.value = norm_zero ? 48'sd0 : r[47:0];
      s.zero_norm = norm_zero;
      sums_due.push_back(s);
    end else begin
      if (e.mode == MODE_L2) term = (a - b) * (a - b);
      else if (e.mode == MODE_DOT) term = a * b;
      else term = a * a;
      acc = sat48(acc + sat48(term));
      if (vend) begin
        s.value = acc[47:0];
        if (e.mode == MODE_NORM) begin
          norm_zero = (acc <= 0);
          inv_pred = norm_zero ? 40'd0 : inv_root_of(acc[47:0]);
          s.zero_norm = norm_zero;
        end
        sums_due.push_back(s);
      end
    end
    if (vend) begin
      acc = 0;
      elem_cnt = 0;
    end else begin
      elem_cnt++;
    end
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'(int'($urandom_range(0, 127)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add(logic [1:0] m, logic signed [15:0] a, logic signed [15:0] b,
                     logic l, bit h = 1'b0);
    elem_t e;
    e.mode = m;
    e.a = a;
    e.b = b;
    e.last = l;
    e.hold = h;
    pending.push_back(e);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (out_gap > 0) out_gap <= out_gap - 1;
      else if (!quiet && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 9);
      out_stall <= (out_gap > 0) && !quiet;
      if (!in_valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending.size() > 0 && pending[0].hold && !holding) begin
          holding <= 1'b1;
          hold_cnt <= HOLD_CYCLES;
        end else if (holding) begin
          if (sums_due.size() == 0) begin
            if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
            else begin
              holding <= 1'b0;
              pending[0].hold = 0;
            end
          end
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_mode <= cur.mode;
          in_elem_a <= cur.a;
          in_elem_b <= cur.b;
          in_last <= cur.last;
          in_valid <= 1'b1;
        end
      end
      quiet <= pending.size() < 100;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_elem(cur);
        in_valid <= 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 9);
      end
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          failed = 1;
          if (mismatches < 10)
            $display("unexpected transfer value=%0d zero_norm=%0b eov=%0b",
                     out_value, out_zero_norm, out_end_of_vector);
          mismatches++;
        end else begin
          if (out_value !== sums_due[0].value || out_zero_norm !== sums_due[0].zero_norm
              || out_end_of_vector !== sums_due[0].eov) begin
            failed = 1;
            if (mismatches < 10)
              $display("mismatch exp value=%0d zn=%0b eov=%0b got value=%0d zn=%0b eov=%0b",
                       sums_due[0].value, sums_due[0].zero_norm, sums_due[0].eov,
                       out_value, out_zero_norm, out_end_of_vector);
            mismatches++;
          end
          void'(sums_due.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("vector_distance_normalize test failed");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n, m, len;
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    in_mode = MODE_L2;
    in_elem_a = '0;
    in_elem_b = '0;
    in_last = 0;
    acc = 0;
    inv_pred = '0;
    norm_zero = 1;
    elem_cnt = 0;
    mismatches = 0;
    idle_cycles = 0;
    in_gap = 0;
    out_gap = 0;
    hold_cnt = 0;
    quiet = 0;
    holding = 0;
    failed = 0;

    add(MODE_SCALE, 16'sh7FFF, 16'sd0, 1'b1);
    add(MODE_L2, 16'sh7FFF, 16'sh8000, 1'b0);
    add(MODE_L2, 16'sh8000, 16'sh7FFF, 1'b1);
    add(MODE_DOT, 16'sh8000, 16'sh8000, 1'b0);
    add(MODE_DOT, 16'sh7FFF, 16'sh8000, 1'b1);
    add(MODE_NORM, 16'sd0, 16'sh7FFF, 1'b1);
    add(MODE_SCALE, 16'sh1234, 16'sd0, 1'b1);
    add(MODE_NORM, 16'sd1, 16'sd0, 1'b1);
    add(MODE_SCALE, 16'sh7FFF, 16'sd0, 1'b0);
    add(MODE_SCALE, 16'sh8000, 16'sd0, 1'b0);
    add(MODE_SCALE, 16'sd0, 16'sd0, 1'b1);
    add(MODE_NORM, 16'sh4000, 16'sd0, 1'b1, 1'b1);
    add(MODE_SCALE, 16'sh4000, 16'sd0, 1'b0);
    add(MODE_SCALE, 16'shC000, 16'sd0, 1'b1);
    add(MODE_NORM, 16'sh8000, 16'sd0, 1'b0);
    add(MODE_DOT, 16'sh7FFF, 16'sh7FFF, 1'b0);
    add(MODE_L2, 16'sh0100, 16'shFF00, 1'b0);
    add(MODE_NORM, 16'sh0003, 16'sd0, 1'b1);
    add(MODE_SCALE, 16'sh0003, 16'sd0, 1'b0);
    add(MODE_DOT, 16'sh0005, 16'sh0007, 1'b1);
    for (int i = 0; i < VEC_MAX; i++) add(MODE_NORM, 16'sh8000, 16'sd0, 1'b0);
    add(MODE_SCALE, 16'sh7FFF, 16'sd0, 1'b1);

    n = 0;
    while (n < 130) begin
      m = $urandom_range(0, 9);
      len = $urandom_range(1, 8);
      if (m < 7) begin
        m = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
          add(m[1:0], pick_elem(), pick_elem(), i == len - 1);
        if (m == MODE_NORM)
          for (int i = 0; i < len; i++) add(MODE_SCALE, pick_elem(), pick_elem(), i == len - 1);
        n += (m == MODE_NORM) ? 2 * len : len;
      end else begin
        for (int i = 0; i < len; i++)
          add(2'($urandom), pick_elem(), pick_elem(), $urandom_range(0, 3) == 0);
        n += len;
      end
    end
    add(MODE_NORM, 16'sh0010, 16'sd0, 1'b1, 1'b1);

    repeat (12) @(posedge clk);
    rst_n <= 1;
    wait (pending.size() == 0 && !in_valid && !holding);
    wait (sums_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && sums_due.size() == 0)
      $display("vector_distance_normalize test passed");
    else
      $display("vector_distance_normalize test failed");
    $finish;
  end
endmodule
